>>> hw/rtl/quicksort_engine_macros.svh
// ----------------------------------------------------------------------------
// quicksort_engine_macros.svh
// Assertion helpers shared by the quicksort engine RTL.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_ENGINE_MACROS_SVH
`define QUICKSORT_ENGINE_MACROS_SVH

// base form: property checked on the rising clock, quiet during reset
`define QSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("quicksort_engine: assertion failed");

// same-cycle implication
`define QSE_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  `QSE_ASSERT(lbl, clk, rst_n, (pre) |-> (post))

// next-cycle implication
`define QSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  `QSE_ASSERT(lbl, clk, rst_n, (pre) |=> (post))

`endif

>>> hw/rtl/qsort_pkg.sv
// ----------------------------------------------------------------------------
// qsort_pkg
// Shared sizes and types of the quicksort engine.
// ----------------------------------------------------------------------------
package qsort_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // one pending (low, high) range on the stack
  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  // sequencer to output register
  typedef struct packed {
    logic  valid;
    data_t value;
    logic  last;
  } emit_t;

endpackage

>>> hw/rtl/qsort_if.sv
// ----------------------------------------------------------------------------
// qsort_if
// Valid/ready channels of the quicksort engine: element in, sorted element out.
// ----------------------------------------------------------------------------
interface qsort_in_if;
  logic                valid;
  logic                ready;
  qsort_pkg::data_t    value;
  logic                last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface qsort_out_if;
  logic                valid;
  logic                ready;
  qsort_pkg::data_t    sorted_value;
  logic                last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

>>> hw/rtl/qsort_seq.sv
// ----------------------------------------------------------------------------
// qsort_seq
// Sequencer: element store, range stack, shared compare, load/sort/emit steps.
// ----------------------------------------------------------------------------
module qsort_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  qsort_pkg::data_t   in_value_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output qsort_pkg::emit_t   emit_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_SW2   = 4'd7;
  localparam logic [3:0] S_FIN1  = 4'd8;
  localparam logic [3:0] S_FIN2  = 4'd9;
  localparam logic [3:0] S_PUSH2 = 4'd10;
  localparam logic [3:0] S_EMRD  = 4'd11;
  localparam logic [3:0] S_EMW   = 4'd12;

  localparam qsort_pkg::cnt_t CntMax = qsort_pkg::CNT_W'(qsort_pkg::MAX_ITEMS);
  localparam qsort_pkg::cnt_t CntOne = qsort_pkg::CNT_W'(1);
  localparam qsort_pkg::cnt_t CntTwo = qsort_pkg::CNT_W'(2);
  localparam qsort_pkg::idx_t IdxOne = qsort_pkg::IDX_W'(1);

  logic [3:0]         state_q, state_d;
  qsort_pkg::cnt_t    cnt_q, cnt_d;
  qsort_pkg::cnt_t    sp_q, sp_d;
  qsort_pkg::idx_t    lo_q, lo_d, hi_q, hi_d;
  qsort_pkg::idx_t    j_q, j_d, nx_q, nx_d, k_q, k_d;
  qsort_pkg::data_t   pivot_q, pivot_d, tmp_q, tmp_d;

  // element store: one write port, two registered read ports
  qsort_pkg::data_t   elem_mem [qsort_pkg::MAX_ITEMS];
  qsort_pkg::data_t   rd_a_q, rd_b_q;
  logic               mem_we;
  qsort_pkg::idx_t    mem_waddr, rd_a_addr, rd_b_addr;
  qsort_pkg::data_t   mem_wdata;

  // range stack: one write port, one registered read port
  qsort_pkg::range_t  stk_mem [qsort_pkg::MAX_ITEMS];
  qsort_pkg::range_t  stk_rd_q;
  logic               stk_we;
  qsort_pkg::range_t  stk_wdata;
  qsort_pkg::idx_t    stk_raddr;

  qsort_pkg::cnt_t    sp_m1;
  qsort_pkg::cnt_t    cnt_m1;
  logic               le_pivot;
  logic               sp_room;

  assign sp_m1    = sp_q - CntOne;
  assign cnt_m1   = cnt_q - CntOne;
  assign sp_room  = (sp_q < CntMax);
  // the shared compare unit: element against pivot, signed
  assign le_pivot = (rd_a_q <= pivot_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= elem_mem[rd_a_addr];
    rd_b_q <= elem_mem[rd_b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[sp_q[qsort_pkg::IDX_W-1:0]] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sp_d       = sp_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    j_d        = j_q;
    nx_d       = nx_q;
    k_d        = k_q;
    pivot_d    = pivot_q;
    tmp_d      = tmp_q;
    mem_we     = 1'b0;
    mem_waddr  = nx_q;
    mem_wdata  = rd_a_q;
    rd_a_addr  = j_q;
    rd_b_addr  = nx_q;
    stk_we     = 1'b0;
    stk_wdata  = '{lo: lo_q, hi: hi_q};
    stk_raddr  = sp_m1[qsort_pkg::IDX_W-1:0];
    in_ready_o = 1'b0;
    emit_o     = '{valid: 1'b0, value: rd_a_q, last: 1'b0};

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CntMax) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[qsort_pkg::IDX_W-1:0];
            mem_wdata = in_value_i;
            cnt_d     = cnt_q + CntOne;
          end
          if (in_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (cnt_q >= CntTwo) begin
          stk_we    = 1'b1;
          stk_wdata = '{lo: '0, hi: cnt_m1[qsort_pkg::IDX_W-1:0]};
          sp_d      = sp_q + CntOne;
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = (cnt_q == '0) ? S_LOAD : S_EMRD;
        end else begin
          sp_d    = sp_m1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        lo_d      = stk_rd_q.lo;
        hi_d      = stk_rd_q.hi;
        j_d       = stk_rd_q.lo;
        nx_d      = stk_rd_q.lo;
        rd_a_addr = stk_rd_q.hi;
        state_d   = (stk_rd_q.lo >= stk_rd_q.hi) ? S_POP : S_PIV;
      end
      S_PIV: begin
        pivot_d = rd_a_q;
        state_d = S_RD;
      end
      S_RD: begin
        rd_a_addr = j_q;
        rd_b_addr = nx_q;
        state_d   = (j_q == hi_q) ? S_FIN1 : S_CMP;
      end
      S_CMP: begin
        if (le_pivot) begin
          // first half of the swap: element goes to the next low slot
          mem_we    = 1'b1;
          mem_waddr = nx_q;
          mem_wdata = rd_a_q;
          tmp_d     = rd_b_q;
          state_d   = S_SW2;
        end else begin
          j_d     = j_q + IdxOne;
          state_d = S_RD;
        end
      end
      S_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = tmp_q;
        j_d       = j_q + IdxOne;
        nx_d      = nx_q + IdxOne;
        state_d   = S_RD;
      end
      S_FIN1: begin
        mem_we    = 1'b1;
        mem_waddr = nx_q;
        mem_wdata = pivot_q;
        tmp_d     = rd_b_q;
        state_d   = S_FIN2;
      end
      S_FIN2: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = tmp_q;
        // right part, pivot+1 .. hi
        if (((qsort_pkg::CNT_W'(nx_q) + CntOne) < qsort_pkg::CNT_W'(hi_q)) && sp_room) begin
          stk_we    = 1'b1;
          stk_wdata = '{lo: nx_q + IdxOne, hi: hi_q};
          sp_d      = sp_q + CntOne;
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        // left part, lo .. pivot-1
        if (((qsort_pkg::CNT_W'(lo_q) + CntOne) < qsort_pkg::CNT_W'(nx_q)) && sp_room) begin
          stk_we    = 1'b1;
          stk_wdata = '{lo: lo_q, hi: nx_q - IdxOne};
          sp_d      = sp_q + CntOne;
        end
        state_d = S_POP;
      end
      S_EMRD: begin
        rd_a_addr = k_q;
        state_d   = S_EMW;
      end
      S_EMW: begin
        rd_a_addr = k_q;
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.last  = ((qsort_pkg::CNT_W'(k_q) + CntOne) == cnt_q);
          if (emit_o.last) begin
            cnt_d   = '0;
            sp_d    = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + IdxOne;
            state_d = S_EMRD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    j_q     <= j_d;
    nx_q    <= nx_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    tmp_q   <= tmp_d;
  end

endmodule

>>> hw/rtl/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects a set of signed words, sorts it in place by Lomuto quicksort and
// streams the sorted set back out.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                 transfer
//   in_i     in   value, last_in          valid & ready; ready only while loading
//   out_o    out  sorted_value, last_out  valid & ready; registered output
//
// Loading: one transfer per cycle; the transfer with last_in closes the set.
// Sorting: each scanned element is read and compared with the pivot, and one that moves
// is swapped; each range adds pop, pivot read, final pivot swap and pushes of its parts.
// Output: each element is read from the store, then handed to the output register.
// Reset clears sequencer, fill count and stack pointer; the stores have no reset.
// A stalled out_o holds the emit step; the next set may load while the final one waits.
//
// ----------------------------------------------------------------------------
`include "quicksort_engine_macros.svh"

module quicksort_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  qsort_in_if.sink    in_i,
  qsort_out_if.source out_o
);

  logic               in_ready;
  logic               out_free;
  qsort_pkg::emit_t   emit;

  // output register
  logic               out_valid_q;
  qsort_pkg::data_t   out_value_q;
  logic               out_last_q;

  // slot is free when empty or being taken in this cycle
  assign out_free = !out_valid_q || out_o.ready;

  qsort_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_value_i (in_i.value),
    .in_last_i  (in_i.last_in),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .emit_o     (emit)
  );

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_value_q <= emit.value;
      out_last_q  <= emit.last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.last_out     = out_last_q;

  // emission never overlaps loading
  `QSE_ASSERT_IMP(a_emit_not_loading, clk_i, rst_ni, emit.valid, !in_ready)
  // sequencer only hands over an element when the output slot can take it
  `QSE_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, emit.valid, out_free)
  // after the final element the block is back to loading
  `QSE_ASSERT_NEXT(a_load_after_final, clk_i, rst_ni, emit.valid && emit.last, in_ready)

endmodule
